/* src/lpgd_pkg.sv */
// Shared types and constants for the length-prefixed goto deframer.
// No dependencies; every other file imports this package.
package lpgd_pkg;

  localparam int MAX_PACKET  = 4096;
  localparam int MIN_LENGTH  = 4;
  localparam int GOTO_LENGTH = 20;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
  } lpgd_in_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [15:0]        packet_length;
    logic [15:0]        packet_type;
    logic [31:0]        ra_raw;
    logic signed [31:0] dec_raw;
  } lpgd_out_t;

  typedef enum logic [1:0] {
    KIND_GOTO    = 2'd0,
    KIND_IGNORED = 2'd1,
    KIND_BAD_LEN = 2'd2
  } lpgd_kind_t;

  // Work the back end does for one queued byte.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_BAD_LEN,
    OP_TYPE_LO,
    OP_TYPE_HI,
    OP_RA,
    OP_DEC
  } lpgd_op_t;

  typedef struct packed {
    lpgd_op_t    op;
    logic [7:0]  data;
    logic [1:0]  lane;
    logic        last;
    logic [15:0] length;
  } lpgd_cmd_t;

endpackage

/* src/lpgd_front.sv */
// Front end: tracks the byte position, captures the length field and
// classifies each byte into a back-end command. Depends on lpgd_pkg.
module lpgd_front import lpgd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  lpgd_in_t  in_data,
  output logic      push,
  output lpgd_cmd_t cmd
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pos;
  logic [15:0] len_full;
  logic        len_bad;
  logic        is_last;

  always_comb begin
    pos      = in_data.new_connection ? 16'd0 : pos_r;
    len_full = {in_data.data_byte, len_r[7:0]};
    len_bad  = (len_full < 16'(MIN_LENGTH)) || (len_full > 16'(MAX_PACKET));
    is_last  = ({1'b0, pos} + 17'd1) >= {1'b0, len_r};

    pos_nxt     = pos_r;
    len_nxt     = len_r;
    cmd.op      = OP_NONE;
    cmd.data    = in_data.data_byte;
    cmd.lane    = pos[1:0];
    cmd.last    = 1'b0;
    cmd.length  = len_r;

    if (pos == 16'd0) begin
      len_nxt = {8'd0, in_data.data_byte};
      pos_nxt = 16'd1;
      cmd.op  = OP_START;
    end else if (pos == 16'd1) begin
      len_nxt    = len_full;
      cmd.length = len_full;
      if (len_bad) begin
        cmd.op  = OP_BAD_LEN;
        pos_nxt = 16'd0;
      end else begin
        pos_nxt = 16'd2;
      end
    end else begin
      if (pos == 16'd2) begin
        cmd.op = OP_TYPE_LO;
      end else if (pos == 16'd3) begin
        cmd.op = OP_TYPE_HI;
      end else if (pos >= 16'd12 && pos <= 16'd15) begin
        cmd.op = OP_RA;
      end else if (pos >= 16'd16 && pos <= 16'd19) begin
        cmd.op = OP_DEC;
      end
      cmd.last = is_last;
      pos_nxt  = is_last ? 16'd0 : pos + 16'd1;
    end

    // Drop bytes the back end has nothing to do with.
    push = accept && ((cmd.op != OP_NONE) || cmd.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

/* src/lpgd_queue.sv */
// Small command queue between front and back end.
// Depends on lpgd_pkg for the command type.
module lpgd_queue import lpgd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lpgd_cmd_t push_data,
  output logic      full,
  input  logic      pop,
  output lpgd_cmd_t pop_data,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lpgd_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* src/lpgd_back.sv */
// Back end: assembles type and angle words from queued commands and
// drives the registered result request. Depends on lpgd_pkg.
module lpgd_back import lpgd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_avail,
  input  lpgd_cmd_t cmd,
  output logic      cmd_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output lpgd_out_t out_data
);

  logic [15:0] type_r, type_nxt;
  logic [31:0] ra_r, ra_nxt;
  logic [31:0] dec_r, dec_nxt;
  logic        out_valid_r;
  lpgd_out_t   out_data_r;
  logic        emit;
  lpgd_out_t   res;
  logic [31:0] lane_bits;

  assign cmd_pop   = cmd_avail && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    type_nxt  = type_r;
    ra_nxt    = ra_r;
    dec_nxt   = dec_r;
    lane_bits = 32'(cmd.data) << {cmd.lane, 3'b000};
    emit      = 1'b0;
    res       = '0;

    unique case (cmd.op)
      OP_START: begin
        type_nxt = '0;
        ra_nxt   = '0;
        dec_nxt  = '0;
      end
      OP_TYPE_LO: type_nxt = {8'd0, cmd.data};
      OP_TYPE_HI: type_nxt = {cmd.data, type_r[7:0]};
      OP_RA:      ra_nxt   = ra_r | lane_bits;
      OP_DEC:     dec_nxt  = dec_r | lane_bits;
      OP_BAD_LEN, OP_NONE: begin
      end
      default: begin
      end
    endcase

    if (cmd.op == OP_BAD_LEN) begin
      emit              = 1'b1;
      res.event_kind    = KIND_BAD_LEN;
      res.packet_length = cmd.length;
    end else if (cmd.last) begin
      emit              = 1'b1;
      res.packet_length = cmd.length;
      res.packet_type   = type_nxt;
      if (type_nxt == 16'd0 && cmd.length == 16'(GOTO_LENGTH)) begin
        res.event_kind = KIND_GOTO;
        res.ra_raw     = ra_nxt;
        res.dec_raw    = dec_nxt;
      end else begin
        res.event_kind = KIND_IGNORED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r      <= '0;
      ra_r        <= '0;
      dec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        type_r <= type_nxt;
        ra_r   <= ra_nxt;
        dec_r  <= dec_nxt;
      end
      if (cmd_pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && emit) begin
      out_data_r <= res;
    end
  end

  a_bad_len_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_kind == KIND_BAD_LEN) |->
      (out_data_r.packet_type == '0 && out_data_r.ra_raw == '0 &&
       out_data_r.dec_raw == '0))
    else $error("bad-length result carries nonzero fields");

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_kind == KIND_IGNORED) |->
      (out_data_r.ra_raw == '0 && out_data_r.dec_raw == '0))
    else $error("ignored-packet result carries angle data");

  a_goto_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.event_kind == KIND_GOTO) |->
      (out_data_r.packet_length == 16'(GOTO_LENGTH) &&
       out_data_r.packet_type == '0))
    else $error("goto result with wrong length or type");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd_pop)
    else $error("command popped while result request stalled");

endmodule

/* src/length_prefixed_goto_deframer.sv */
// A result request is registered: the command for a packet's last byte (or
// its second byte, for a bad length) goes through the command queue to the
// back end's output register. Throughput: one byte per cycle; a stalled
// result side backs up the four-entry command queue before in_ready drops.
// Reset (rst_n low, synchronous): byte position, length, queue and output
// valid clear; the first byte after reset is byte 0 of a packet.
module length_prefixed_goto_deframer import lpgd_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lpgd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output lpgd_out_t out_data
);

  // Front to queue: classified command per useful byte.
  logic      in_accept;
  logic      q_push;
  lpgd_cmd_t q_push_cmd;
  logic      q_full;

  // Queue to back end.
  logic      q_pop;
  lpgd_cmd_t q_pop_cmd;
  logic      q_empty;

  // Take a byte whenever the queue has room; framing needs no other wait.
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  // Front: advance byte position, capture length, classify the byte.
  lpgd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_data (in_data),
    .push    (q_push),
    .cmd     (q_push_cmd)
  );

  // Queue: decouple byte intake from result-side stalls.
  lpgd_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_cmd),
    .empty     (q_empty)
  );

  // Back end: build type and angle words, hold the result request
  // in its output register until taken.
  lpgd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_avail (!q_empty),
    .cmd       (q_pop_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
